// ===== rtl/nsfl_pkg.sv =====
package nsfl_pkg;

  localparam int unsigned MAX_SYMBOLS_DEF = 1024;

  localparam int unsigned DATA_W = 32;

  // op codes (s_axis_tuser)
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  // status codes (m_axis_tuser)
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } state_e;

  // which result the output register loads
  typedef enum logic [1:0] {
    RES_OK,
    RES_MISS,
    RES_FULL,
    RES_SCAN
  } res_e;

  typedef struct packed {
    logic latch_in;
    logic clear_do;
    logic append_do;
    logic scan_init;
    logic scan_issue;
    logic out_load;
    res_e out_sel;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       present;
    logic       full;
    logic       scan_more;
    logic       rd_valid;
    logic       out_free;
  } dp_stat_t;

endpackage

// ===== rtl/nearest_symbol_floor_lookup_core.sv =====
// Nearest symbol at or below an address. The core keeps a table of up to
// MAX_SYMBOLS entries (value, name offset) in a single-port-write /
// single-port-read memory. Each input beat carries an op in s_axis_tuser:
// clear empties the table, append stores one entry (status FULL and nothing
// stored when the table is full), lookup scans the stored entries in order
// and returns the largest nonzero value <= query_address, first of equal
// values winning; status MISS when nothing matches or table_present is 0.
// Every input beat yields exactly one output beat, status in m_axis_tuser.
// One beat is processed at a time. Clear, append, absent-table lookup and
// the unused op go from accept straight to the result load; a lookup runs
// scan setup, then the scan that reads one memory entry per cycle through
// one comparator, then the read register stage and the result load. Every
// result load waits while the output register holds an untaken result. A
// new input beat is accepted while a finished result still waits in the
// output register. The table memory comes up undefined and needs no
// clearing pass; only entries below entry_count are ever read.
// table_present is written through cfg_we_i / cfg_data_i; the user must
// write it only while the core is idle (not enforced here); reset value 0.
module nearest_symbol_floor_lookup_core import nsfl_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: table_present
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  // input beat
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // entry_value, entry_name_offset, query_address
  input  logic [1:0]  s_axis_tuser,   // op
  // result beat
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // symbol_value, name_offset
  output logic [1:0]  m_axis_tuser    // status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  nsfl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  nsfl_dp #(
    .MAX_SYMBOLS (MAX_SYMBOLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_op_i      (s_axis_tuser),
    .in_value_i   (s_axis_tdata[31:0]),
    .in_name_i    (s_axis_tdata[63:32]),
    .in_addr_i    (s_axis_tdata[95:64]),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (m_axis_tuser),
    .out_value_o  (m_axis_tdata[31:0]),
    .out_name_o   (m_axis_tdata[63:32])
  );

endmodule

// ===== rtl/nsfl_ctrl.sv =====
module nsfl_ctrl import nsfl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '{default: '0, out_sel: RES_OK};
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        case (stat_i.op)
          OP_CLEAR: begin
            if (stat_i.out_free) begin
              cmd_o.clear_do = 1'b1;
              cmd_o.out_load = 1'b1;
              cmd_o.out_sel  = RES_OK;
              state_d        = S_IDLE;
            end
          end
          OP_APPEND: begin
            if (stat_i.out_free) begin
              cmd_o.out_load = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_sel = RES_FULL;
              end else begin
                cmd_o.append_do = 1'b1;
                cmd_o.out_sel   = RES_OK;
              end
              state_d = S_IDLE;
            end
          end
          OP_LOOKUP: begin
            if (!stat_i.present) begin
              if (stat_i.out_free) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_sel  = RES_MISS;
                state_d        = S_IDLE;
              end
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
          end
          default: begin
            if (stat_i.out_free) begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_sel  = RES_MISS;
              state_d        = S_IDLE;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (stat_i.scan_more) begin
          cmd_o.scan_issue = 1'b1;
        end else if (!stat_i.rd_valid && stat_i.out_free) begin
          // last compare retired
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = RES_SCAN;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/nsfl_dp.sv =====
module nsfl_dp import nsfl_pkg::*; #(
  parameter int unsigned MAX_SYMBOLS = MAX_SYMBOLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          in_op_i,
  input  logic [DATA_W-1:0]   in_value_i,
  input  logic [DATA_W-1:0]   in_name_i,
  input  logic [DATA_W-1:0]   in_addr_i,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_stat_t            stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          out_status_o,
  output logic [DATA_W-1:0]   out_value_o,
  output logic [DATA_W-1:0]   out_name_o
);

  localparam int unsigned CW = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned IW = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  logic [2*DATA_W-1:0] mem_q [MAX_SYMBOLS];

  logic [1:0]          op_q;
  logic [DATA_W-1:0]   val_q, nm_q, addr_q;
  logic                present_q;
  logic [CW-1:0]       count_q, idx_q;
  logic                rd_valid_q;
  logic [2*DATA_W-1:0] rd_data_q;
  logic [DATA_W-1:0]   best_q, best_nm_q;
  logic                hit_q;
  logic                out_valid_q;
  logic [1:0]          out_status_q;
  logic [DATA_W-1:0]   out_val_q, out_nm_q;
  logic [DATA_W-1:0]   rd_val, rd_nm;
  logic                take;

  assign rd_val = rd_data_q[DATA_W-1:0];
  assign rd_nm  = rd_data_q[2*DATA_W-1:DATA_W];
  assign take   = rd_valid_q && (rd_val > best_q) && (rd_val <= addr_q);

  // input capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q   <= in_op_i;
      val_q  <= in_value_i;
      nm_q   <= in_name_i;
      addr_q <= in_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= 1'b0;
    end else if (cfg_we_i) begin
      present_q <= cfg_data_i;
    end
  end

  // symbol table: one write port (append), one read port (scan)
  always_ff @(posedge clk_i) begin
    if (cmd_i.append_do) begin
      mem_q[count_q[IW-1:0]] <= {nm_q, val_q};
    end
    if (cmd_i.scan_issue) begin
      rd_data_q <= mem_q[idx_q[IW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
      hit_q      <= 1'b0;
    end else begin
      if (cmd_i.clear_do) begin
        count_q <= '0;
      end else if (cmd_i.append_do) begin
        count_q <= count_q + CW'(1);
      end
      rd_valid_q <= cmd_i.scan_issue;
      if (cmd_i.scan_init) begin
        idx_q <= '0;
        hit_q <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          idx_q <= idx_q + CW'(1);
        end
        if (take) begin
          hit_q <= 1'b1;
        end
      end
    end
  end

  // running best; strict > keeps the first of equal values
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      best_q    <= '0;
      best_nm_q <= '0;
    end else if (take) begin
      best_q    <= rd_val;
      best_nm_q <= rd_nm;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_sel)
        RES_OK: begin
          out_status_q <= ST_OK;
          out_val_q    <= '0;
          out_nm_q     <= '0;
        end
        RES_FULL: begin
          out_status_q <= ST_FULL;
          out_val_q    <= '0;
          out_nm_q     <= '0;
        end
        RES_SCAN: begin
          out_status_q <= hit_q ? ST_OK : ST_MISS;
          out_val_q    <= hit_q ? best_q : '0;
          out_nm_q     <= hit_q ? best_nm_q : '0;
        end
        default: begin
          out_status_q <= ST_MISS;
          out_val_q    <= '0;
          out_nm_q     <= '0;
        end
      endcase
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.present   = present_q;
  assign stat_o.full      = (count_q == CW'(MAX_SYMBOLS));
  assign stat_o.scan_more = (idx_q < count_q);
  assign stat_o.rd_valid  = rd_valid_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_val_q;
  assign out_name_o   = out_nm_q;

endmodule

// ===== rtl/nsfl_chk.sv =====
module nsfl_chk import nsfl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // one beat at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("back-to-back accept");

  // only a found lookup carries data
  a_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_MISS || m_axis_tuser == ST_FULL) |->
      m_axis_tdata == 64'd0)
    else $error("nonzero payload on miss or full");

  // a name offset comes only with a nonzero matched value
  a_found_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[63:32] != 32'd0 |->
      m_axis_tdata[31:0] != 32'd0 && m_axis_tuser == ST_OK)
    else $error("name offset without a match");

endmodule

bind nearest_symbol_floor_lookup_core nsfl_chk u_nsfl_chk (.*);

// ===== tb/sv/tb_nearest_symbol_floor_lookup_core.sv =====
`timescale 1ns / 1ps

module tb_nearest_symbol_floor_lookup_core;
  import nsfl_pkg::*;

  localparam int unsigned TBL_DEPTH   = MAX_SYMBOLS_DEF;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned RESET_CYC   = 6;
  // a full-table scan is the longest the core can go quiet on its own
  localparam int unsigned DRAIN_CYC   = TBL_DEPTH + 8;
  localparam int unsigned HOLD_CYC    = 300;
  // quiet gaps: full scan plus stalls, receiver hold-off, drain; wide margin
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PHASE_BEATS = 145;
  localparam int unsigned MAX_PRINT   = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [31:0] name;
  } floor_result_t;

  class floor_scoreboard;
    logic [31:0]   sym_value [TBL_DEPTH];
    logic [31:0]   sym_name  [TBL_DEPTH];
    int unsigned   sym_count;
    logic          present;
    floor_result_t due_results[$];
    int unsigned   mismatches;

    function new();
      sym_count  = 0;
      present    = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return due_results.size();
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINT) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // predicted result of one accepted request beat
    function void take_request(logic [1:0] op, logic [31:0] val, logic [31:0] nm,
                               logic [31:0] qa);
      floor_result_t r;
      logic [31:0]   best;
      logic [31:0]   best_name;
      logic          hit;
      int unsigned   i;
      r = '{status: ST_OK, value: 32'd0, name: 32'd0};
      case (op)
        OP_CLEAR: sym_count = 0;
        OP_APPEND: begin
          if (sym_count < TBL_DEPTH) begin
            sym_value[sym_count] = val;
            sym_name[sym_count]  = nm;
            sym_count++;
          end else begin
            r.status = ST_FULL;
          end
        end
        OP_LOOKUP: begin
          best      = 32'd0;
          best_name = 32'd0;
          hit       = 1'b0;
          // zero entries never beat best = 0; strict > keeps the first of equals
          if (present) begin
            for (i = 0; i < sym_count; i++) begin
              if (sym_value[i] > best && sym_value[i] <= qa) begin
                best      = sym_value[i];
                best_name = sym_name[i];
                hit       = 1'b1;
              end
            end
          end
          if (hit) r = '{status: ST_OK, value: best, name: best_name};
          else r.status = ST_MISS;
        end
        default: r.status = ST_MISS;
      endcase
      due_results.push_back(r);
    endfunction

    task check_result(logic [1:0] st, logic [31:0] val, logic [31:0] nm);
      floor_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("result with nothing pending: status %0d value %h name %h",
                         st, val, nm));
        return;
      end
      want = due_results.pop_front();
      if (st !== want.status)
        report($sformatf("status got %0d want %0d", st, want.status));
      if (val !== want.value)
        report($sformatf("symbol_value got %h want %h", val, want.value));
      if (nm !== want.name)
        report($sformatf("name_offset got %h want %h", nm, want.name));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // entry_value, entry_name_offset, query_address
  logic [1:0]  s_axis_tuser;   // op
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // symbol_value, name_offset
  logic [1:0]  m_axis_tuser;   // status

  floor_scoreboard sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     rcv_stall_pct = 0;
  bit              hold_req      = 1'b0;
  int unsigned     beats_sent    = 0;
  int unsigned     quiet_cycles  = 0;
  logic [31:0]     recent_vals[$];

  always #5 clk_i = ~clk_i;

  nearest_symbol_floor_lookup_core #(
    .MAX_SYMBOLS(TBL_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // receiver: random stalls, or one long hold-off when asked
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYC - 1) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.present = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32]);
      if (s_axis_tvalid && s_axis_tready)
        sb.take_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                        s_axis_tdata[95:64]);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[nearest_symbol_floor_lookup_core] ERROR");
      $finish;
    end
  end

  task automatic send_beat(input logic [1:0] op, input logic [31:0] val,
                           input logic [31:0] nm, input logic [31:0] qa);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {qa, nm, val};
    do @(posedge clk_i); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_clear();
    send_beat(OP_CLEAR, $urandom(), $urandom(), $urandom());
    recent_vals.delete();
  endtask

  task automatic send_append(input logic [31:0] val, input logic [31:0] nm);
    send_beat(OP_APPEND, val, nm, $urandom());
    recent_vals.push_back(val);
  endtask

  task automatic send_lookup(input logic [31:0] qa);
    send_beat(OP_LOOKUP, $urandom(), $urandom(), qa);
  endtask

  // stop offering, wait for every result, then a short pause
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_present(input logic v);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  function automatic logic [31:0] recent_pick();
    return recent_vals[$urandom_range(recent_vals.size() - 1)];
  endfunction

  // small values and repeats give ties and near misses
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2, 3:    return $urandom();
      4, 5, 6: return $urandom_range(255, 1);
      default: return (recent_vals.size() != 0) ? recent_pick() + $urandom_range(2)
                                                : $urandom_range(64);
    endcase
  endfunction

  function automatic logic [31:0] pick_query();
    if (recent_vals.size() == 0) return $urandom();
    case ($urandom_range(9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom();
      3:       return $urandom_range(300);
      4, 5:    return recent_pick();
      6:       return recent_pick() - 32'd1;
      7:       return recent_pick() + 32'd1;
      default: return recent_pick() + $urandom_range(200);
    endcase
  endfunction

  // mostly clear / appends / lookups runs, some raw noise beats
  task automatic random_phase(input int unsigned n_beats, input bit with_hold);
    int unsigned first_beat;
    int unsigned k;
    bit          hold_done;
    logic [1:0]  op;
    first_beat = beats_sent;
    hold_done  = 1'b0;
    while (beats_sent - first_beat < n_beats) begin
      if (with_hold && !hold_done && beats_sent - first_beat >= 60) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        op = 2'($urandom_range(3));
        send_beat(op, $urandom(), $urandom(), $urandom());
        if (op == OP_CLEAR) recent_vals.delete();
      end else begin
        if (recent_vals.size() > 40 || $urandom_range(3) == 0) send_clear();
        k = $urandom_range(8);
        repeat (k) send_append(pick_value(), $urandom());
        k = $urandom_range(6, 1);
        repeat (k) send_lookup(pick_query());
      end
    end
  endtask

  initial begin
    bit [1:0]    idle_mode [4];
    logic        phase_present [4];
    int unsigned p;
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_CLEAR;
    repeat (RESET_CYC) @(negedge clk_i);
    rst_ni <= 1'b1;

    // table absent after reset: lookups miss, table updates still happen
    send_lookup(32'hFFFF_FFFF);
    send_append(32'h0000_1000, 32'hAAAA_5555);
    send_lookup(32'h0000_1000);
    send_beat(OP_UNUSED, '1, '1, '1);
    send_clear();
    settle();
    set_present(1'b1);

    send_lookup(32'hFFFF_FFFF);               // empty table
    send_append(32'd0, 32'hFFFF_FFFF);        // zero value never matches
    send_lookup(32'd0);
    send_lookup(32'hFFFF_FFFF);
    send_append(32'hFFFF_FFFF, 32'h1234_5678);
    send_append(32'h0000_0100, 32'd1);
    send_append(32'h0000_0100, 32'd2);        // tie, first stored must win
    send_append(32'h0000_0080, 32'd3);
    send_append(32'd1, 32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFF);
    send_lookup(32'hFFFF_FFFE);
    send_lookup(32'h0000_0100);
    send_lookup(32'h0000_00FF);
    send_lookup(32'd1);
    send_lookup(32'd0);
    send_beat(OP_UNUSED, '0, '0, '0);         // must leave the table alone
    send_lookup(32'h0000_0080);
    send_clear();
    send_lookup(32'h0000_0100);
    settle();

    // fill to capacity, overflow twice, scan the full table
    send_clear();
    repeat (TBL_DEPTH) send_append(pick_value(), $urandom());
    send_append(32'h0000_0001, 32'hDEAD_0001);
    send_append(32'hFFFF_FFFF, 32'hDEAD_0002);
    send_lookup(32'hFFFF_FFFF);
    send_lookup($urandom());
    send_lookup(recent_pick());
    send_lookup(32'd0);
    send_clear();
    send_append(32'h0000_0040, 32'h0000_0007);
    send_lookup(32'h0000_0041);
    settle();

    idle_mode     = '{2'd0, 2'd1, 2'd2, 2'd3};
    phase_present = '{1'b1, 1'b1, 1'b0, 1'b1};
    for (p = 0; p < 4; p++) begin
      send_idle_pct = (idle_mode[p] == 2'd1) ? 57 : (idle_mode[p] == 2'd3) ? 27 : 0;
      rcv_stall_pct = (idle_mode[p] == 2'd2) ? 57 : (idle_mode[p] == 2'd3) ? 27 : 0;
      set_present(phase_present[p]);
      random_phase(PHASE_BEATS, p == 0);
      settle();
    end

    repeat (DRAIN_CYC) @(posedge clk_i);
    while (sb.pending() != 0) begin
      sb.report("expected result never arrived");
      void'(sb.due_results.pop_front());
    end
    if (sb.mismatches == 0) begin
      $display("[nearest_symbol_floor_lookup_core] OK");
    end else begin
      $display("[nearest_symbol_floor_lookup_core] ERROR");
    end
    $finish;
  end

endmodule
